@@ src/bratu_stencil_residual_core_assert.svh @@
// Assertion macros shared by the core.
`ifndef BRATU_STENCIL_RESIDUAL_CORE_ASSERT_SVH
`define BRATU_STENCIL_RESIDUAL_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define BSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define BSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

    localparam int GRID_W    = 11;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int COEF_W    = 32;
    localparam int REACT_W   = 40;
    localparam int CFG_IDX_W = 3;

    localparam int DIFF_W = VAL_W + 2;
    localparam int PROD_W = COEF_W + 1 + DIFF_W;
    localparam int LIN_W  = PROD_W - 24;
    localparam int T_W    = 44;
    localparam int RES_W  = T_W + 2;
    localparam int K_W    = 10;
    localparam int M_W    = 34;
    localparam int Q_W    = 54;

    localparam logic [GRID_W-1:0]  MAX_GRID      = 11'd1024;
    localparam logic [GRID_W-1:0]  GRID_RESET    = 11'd3;
    localparam logic [COEF_W-1:0]  COEF_RESET    = 32'd16777216;
    localparam logic [REACT_W-1:0] REACT_RESET   = 40'd4294967296;

    localparam logic signed [VAL_W-1:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic [31:0]             LN2_Q32   = 32'd2977044472;
    localparam logic [M_W-1:0]          M_ONE     = 34'h1_0000_0000;
    localparam logic [T_W-1:0]          REACT_CAP = 44'h800_0000_0000;
    localparam logic signed [K_W-1:0]   EXP_BIAS  = 10'sd24;

    localparam int TAYLOR_TERMS  = 12;
    localparam int TAYLOR_STAGES = TAYLOR_TERMS - 1;

    // floor(x / n) == (x * TAYLOR_RECIP[n]) >> TAYLOR_SHIFT[n] for every 32-bit x
    localparam logic [32:0] TAYLOR_RECIP [2:TAYLOR_TERMS] = '{
        33'd4294967296, 33'd5726623062, 33'd4294967296, 33'd6871947674,
        33'd5726623062, 33'd4908534053, 33'd4294967296, 33'd7635497416,
        33'd6871947674, 33'd6247225158, 33'd5726623062
    };
    localparam int TAYLOR_SHIFT [2:TAYLOR_TERMS] = '{
        33, 34, 34, 35, 35, 35, 35, 36, 36, 36, 36
    };

    localparam int LIN_LAT = 3;
    localparam int EXP_LAT = 2 + 2 * TAYLOR_STAGES + 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLS = 3'd0,
        CFG_GRID_ROWS = 3'd1,
        CFG_COEF_X    = 3'd2,
        CFG_COEF_Y    = 3'd3,
        CFG_REACTION  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [IDX_W-1:0]        col_index;
        logic [IDX_W-1:0]        row_index;
        logic signed [VAL_W-1:0] center_value;
        logic signed [VAL_W-1:0] west_value;
        logic signed [VAL_W-1:0] east_value;
        logic signed [VAL_W-1:0] south_value;
        logic signed [VAL_W-1:0] north_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] residual;
        logic                    saturated;
        logic                    on_boundary;
    } t_out_item;

endpackage

`default_nettype wire

@@ src/bsr_lin.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsr_lin
    import bsr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [VAL_W-1:0] i_center,
    input  wire logic signed [VAL_W-1:0] i_west,
    input  wire logic signed [VAL_W-1:0] i_east,
    input  wire logic signed [VAL_W-1:0] i_south,
    input  wire logic signed [VAL_W-1:0] i_north,
    input  wire logic [COEF_W-1:0]       i_coef_x,
    input  wire logic [COEF_W-1:0]       i_coef_y,
    output logic signed [LIN_W-1:0]      o_lin
);

    localparam int PAD = EXP_LAT - LIN_LAT;

    logic signed [DIFF_W-1:0] n_dx, n_dy, r_dx, r_dy;
    logic signed [PROD_W-1:0] n_px, n_py, r_px, r_py;
    logic signed [PROD_W:0]   w_sum;
    logic signed [LIN_W-1:0]  r_lin;
    logic signed [LIN_W-1:0]  r_pad [PAD];

    always_comb begin
        n_dx  = (DIFF_W'(i_center) <<< 1) - DIFF_W'(i_west) - DIFF_W'(i_east);
        n_dy  = (DIFF_W'(i_center) <<< 1) - DIFF_W'(i_south) - DIFF_W'(i_north);
        n_px  = $signed({1'b0, i_coef_x}) * r_dx;
        n_py  = $signed({1'b0, i_coef_y}) * r_dy;
        w_sum = (PROD_W + 1)'(r_px) + (PROD_W + 1)'(r_py);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_px     <= n_px;
            r_py     <= n_py;
            r_lin    <= w_sum[PROD_W-1:24];
            r_pad[0] <= r_lin;
            for (int p = 1; p < PAD; p++) begin
                r_pad[p] <= r_pad[p-1];
            end
        end
    end

    assign o_lin = r_pad[PAD-1];

endmodule

`default_nettype wire

@@ src/bsr_exp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsr_exp
    import bsr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [VAL_W-1:0] i_center,
    input  wire logic [REACT_W-1:0]      i_reaction_coef,
    output logic [T_W-1:0]               o_term,
    output logic                         o_sat
);

    localparam int LAST = TAYLOR_STAGES - 1;
    localparam logic signed [K_W-1:0] LSH_MAX = 10'sd43;

    logic signed [63:0]       w_t;
    logic signed [K_W-1:0]    r1_k, r2_k;
    logic [31:0]              r1_f;
    logic [63:0]              w_r;
    logic [31:0]              r2_r;

    logic [31:0]              w_tin [TAYLOR_STAGES];
    logic [31:0]              w_rin [TAYLOR_STAGES];
    logic [M_W-1:0]           w_min [TAYLOR_STAGES];
    logic signed [K_W-1:0]    w_kin [TAYLOR_STAGES];
    logic [63:0]              w_x   [TAYLOR_STAGES];
    logic [64:0]              w_q   [TAYLOR_STAGES];
    logic [64:0]              w_qs  [TAYLOR_STAGES];

    logic [31:0]              ra_x  [TAYLOR_STAGES];
    logic [31:0]              ra_r  [TAYLOR_STAGES];
    logic [M_W-1:0]           ra_m  [TAYLOR_STAGES];
    logic signed [K_W-1:0]    ra_k  [TAYLOR_STAGES];
    logic [31:0]              rb_t  [TAYLOR_STAGES];
    logic [31:0]              rb_r  [TAYLOR_STAGES];
    logic [M_W-1:0]           rb_m  [TAYLOR_STAGES];
    logic signed [K_W-1:0]    rb_k  [TAYLOR_STAGES];

    logic [M_W-1:0]           r25_m;
    logic signed [K_W-1:0]    r25_k, r26_k;
    logic [Q_W-1:0]           r26_a, r26_b, r27_q;
    logic signed [K_W-1:0]    r27_e;

    logic                     w_neg;
    logic [5:0]               w_lsh, w_rsh;
    logic [K_W-1:0]           w_nsh;
    logic [T_W-1:0]           w_cap_sh;
    logic [Q_W-1:0]           w_qr;
    logic [T_W-1:0]           n_term, r_term;
    logic                     n_sat, r_sat;

    assign w_t = i_center * LOG2E_Q30;
    assign w_r = 64'(r1_f) * 64'(LN2_Q32);

    always_comb begin
        w_tin[0] = r2_r;
        w_rin[0] = r2_r;
        w_min[0] = M_ONE;
        w_kin[0] = r2_k;
        for (int g = 1; g < TAYLOR_STAGES; g++) begin
            w_tin[g] = rb_t[g-1];
            w_rin[g] = rb_r[g-1];
            w_min[g] = rb_m[g-1];
            w_kin[g] = rb_k[g-1];
        end
        for (int g = 0; g < TAYLOR_STAGES; g++) begin
            w_x[g]  = 64'(w_tin[g]) * 64'(w_rin[g]);
            w_q[g]  = 65'(ra_x[g]) * 65'(TAYLOR_RECIP[g+2]);
            w_qs[g] = w_q[g] >> TAYLOR_SHIFT[g+2];
        end
    end

    always_comb begin
        w_neg    = r27_e[K_W-1];
        w_lsh    = r27_e[5:0];
        w_nsh    = -r27_e;
        w_rsh    = (w_nsh > K_W'(63)) ? 6'd63 : w_nsh[5:0];
        w_cap_sh = REACT_CAP >> w_lsh;
        w_qr     = r27_q >> w_rsh;
        n_term   = '0;
        n_sat    = 1'b0;
        if (r27_q != '0) begin
            if (!w_neg) begin
                if (r27_e > LSH_MAX || r27_q > Q_W'(w_cap_sh)) begin
                    n_term = REACT_CAP;
                    n_sat  = 1'b1;
                end else begin
                    n_term = r27_q[T_W-1:0] << w_lsh;
                end
            end else if (w_qr > Q_W'(REACT_CAP)) begin
                n_term = REACT_CAP;
                n_sat  = 1'b1;
            end else begin
                n_term = w_qr[T_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_k <= w_t[63:54];
            r1_f <= w_t[53:22];
            r2_k <= r1_k;
            r2_r <= w_r[63:32];
            for (int g = 0; g < TAYLOR_STAGES; g++) begin
                ra_x[g] <= w_x[g][63:32];
                ra_m[g] <= w_min[g] + M_W'(w_tin[g]);
                ra_r[g] <= w_rin[g];
                ra_k[g] <= w_kin[g];
                rb_t[g] <= w_qs[g][31:0];
                rb_m[g] <= ra_m[g];
                rb_r[g] <= ra_r[g];
                rb_k[g] <= ra_k[g];
            end
            r25_m  <= rb_m[LAST] + M_W'(rb_t[LAST]);
            r25_k  <= rb_k[LAST];
            r26_a  <= Q_W'(r25_m) * Q_W'(i_reaction_coef[REACT_W-1:20]);
            r26_b  <= Q_W'(r25_m) * Q_W'(i_reaction_coef[19:0]);
            r26_k  <= r25_k;
            r27_q  <= r26_a + (r26_b >> 20);
            r27_e  <= r26_k - EXP_BIAS;
            r_term <= n_term;
            r_sat  <= n_sat;
        end
    end

    assign o_term = r_term;
    assign o_sat  = r_sat;

endmodule

`default_nettype wire

@@ src/bratu_stencil_residual_core.sv @@
// Bratu residual core: one grid point in, one residual out.
// Input channel (i_in_valid / o_in_ready / i_in_item): grid indices plus the
// center value and its four neighbors, signed Q8.24. Output channel
// (o_out_valid / i_out_ready / o_out_item): residual in signed Q8.24, a flag
// for clipping and a flag for boundary points, which pass the center value.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
// i_cfg_data) is always ready; write it only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled. The
// pipeline depth from acceptance to o_out_valid is set by the exponential
// path, which steps through eleven Taylor terms at two multiplier stages
// each, plus range reduction and the reaction product.
// A stall on the output freezes the whole pipeline; a one-entry skid
// register takes one more input beat while frozen, so o_in_ready comes from
// a register and never from i_out_ready.
// Synchronous reset clears every valid bit and the skid register and loads
// the register defaults: 3 x 3 grid, both coefficients 1.0, reaction 1/16.
`timescale 1ns / 1ps
`default_nettype none
`include "bratu_stencil_residual_core_assert.svh"

module bratu_stencil_residual_core
    import bsr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_item,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [REACT_W-1:0]   i_cfg_data
);

    localparam int SD_LAST = EXP_LAT - 1;
    localparam logic signed [VAL_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] RES_MIN = 32'sh8000_0000;

    logic [GRID_W-1:0]  r_grid_cols, r_grid_rows, w_grid_val;
    logic [COEF_W-1:0]  r_coef_x, r_coef_y;
    logic [REACT_W-1:0] r_reaction;

    logic     w_en, w_in_acc, w_feed_vld;
    t_in_item w_feed_item;
    logic     r_skid_vld, n_skid_vld;
    t_in_item r_skid_item;
    logic     r_s0_vld;
    t_in_item r_s0_item;
    logic     w_bnd;

    logic [EXP_LAT-1:0]      r_sd_vld, r_sd_bnd;
    logic signed [VAL_W-1:0] r_sd_ctr [EXP_LAT];

    logic signed [LIN_W-1:0] w_lin;
    logic [T_W-1:0]          w_term;
    logic                    w_term_sat;
    logic signed [RES_W-1:0] w_diff;
    logic                    w_fit;
    t_out_item               n_out_item, r_out_item;
    logic                    r_out_vld;

    assign o_cfg_ready = 1'b1;
    assign w_grid_val  = (i_cfg_data[GRID_W-1:0] > MAX_GRID) ? MAX_GRID
                                                             : i_cfg_data[GRID_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GRID_RESET;
            r_grid_rows <= GRID_RESET;
            r_coef_x    <= COEF_RESET;
            r_coef_y    <= COEF_RESET;
            r_reaction  <= REACT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRID_COLS: r_grid_cols <= w_grid_val;
                CFG_GRID_ROWS: r_grid_rows <= w_grid_val;
                CFG_COEF_X:    r_coef_x    <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_Y:    r_coef_y    <= i_cfg_data[COEF_W-1:0];
                CFG_REACTION:  r_reaction  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready  = !r_skid_vld;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_en        = !r_out_vld || i_out_ready;
    assign w_feed_vld  = r_skid_vld || w_in_acc;
    assign w_feed_item = r_skid_vld ? r_skid_item : i_in_item;
    assign n_skid_vld  = w_en ? 1'b0 : (r_skid_vld || w_in_acc);

    assign w_bnd = (r_s0_item.col_index == '0) || (r_s0_item.row_index == '0)
                || (GRID_W'(r_s0_item.col_index) + GRID_W'(1) >= r_grid_cols)
                || (GRID_W'(r_s0_item.row_index) + GRID_W'(1) >= r_grid_rows);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
            r_s0_vld   <= 1'b0;
            r_sd_vld   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_skid_vld <= n_skid_vld;
            if (w_en) begin
                r_s0_vld  <= w_feed_vld;
                r_sd_vld  <= {r_sd_vld[EXP_LAT-2:0], r_s0_vld};
                r_out_vld <= r_sd_vld[SD_LAST];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_en) begin
            r_skid_item <= i_in_item;
        end
        if (w_en) begin
            r_s0_item   <= w_feed_item;
            r_sd_bnd    <= {r_sd_bnd[EXP_LAT-2:0], w_bnd};
            r_sd_ctr[0] <= r_s0_item.center_value;
            for (int p = 1; p < EXP_LAT; p++) begin
                r_sd_ctr[p] <= r_sd_ctr[p-1];
            end
            r_out_item  <= n_out_item;
        end
    end

    bsr_lin u_lin (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_center (r_s0_item.center_value),
        .i_west   (r_s0_item.west_value),
        .i_east   (r_s0_item.east_value),
        .i_south  (r_s0_item.south_value),
        .i_north  (r_s0_item.north_value),
        .i_coef_x (r_coef_x),
        .i_coef_y (r_coef_y),
        .o_lin    (w_lin)
    );

    bsr_exp u_exp (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_center        (r_s0_item.center_value),
        .i_reaction_coef (r_reaction),
        .o_term          (w_term),
        .o_sat           (w_term_sat)
    );

    always_comb begin
        w_diff = $signed(RES_W'(w_lin)) - $signed(RES_W'(w_term));
        w_fit  = (&w_diff[RES_W-1:VAL_W-1]) || !(|w_diff[RES_W-1:VAL_W-1]);
        if (r_sd_bnd[SD_LAST]) begin
            n_out_item.residual    = r_sd_ctr[SD_LAST];
            n_out_item.saturated   = 1'b0;
            n_out_item.on_boundary = 1'b1;
        end else begin
            n_out_item.on_boundary = 1'b0;
            n_out_item.saturated   = w_term_sat || !w_fit;
            if (w_fit) begin
                n_out_item.residual = w_diff[VAL_W-1:0];
            end else if (w_diff[RES_W-1]) begin
                n_out_item.residual = RES_MIN;
            end else begin
                n_out_item.residual = RES_MAX;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    `BSR_ASSERT_NEXT(a_skid_catch, i_clk, i_rst_n, w_in_acc && !w_en, r_skid_vld, "beat lost in stall")
    `BSR_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_vld && w_en, r_s0_vld && !r_skid_vld, "skid not drained")
    `BSR_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_sd_vld[SD_LAST] && w_en, o_out_valid, "result dropped")
    `BSR_ASSERT_NOW(a_bnd_clean, i_clk, i_rst_n, o_out_valid && o_out_item.on_boundary, !o_out_item.saturated, "boundary flagged saturated")
    `BSR_ASSERT_NOW(a_sat_rail, i_clk, i_rst_n, o_out_valid && o_out_item.saturated, o_out_item.residual == RES_MIN || o_out_item.residual == RES_MAX, "clip off rail")

endmodule

`default_nettype wire

@@ bench/bratu_stencil_residual_checker.sv @@
`timescale 1ns / 1ps

module bratu_stencil_residual_checker
    import bsr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REACT_W-1:0]   i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_boundary,
    output int                   o_clipped
);

    localparam longint          LOG2_E_FIX = 64'sd1549082005;
    localparam longint unsigned LN_2_FIX   = 64'd2977044472;
    localparam longint unsigned CLIP_T     = 64'd1 << 43;
    localparam int              EXP_TERMS  = 12;
    localparam int              MAX_REPORT = 10;

    logic [10:0] grid_cols;
    logic [10:0] grid_rows;
    logic [31:0] coef_x;
    logic [31:0] coef_y;
    logic [39:0] reaction;

    t_out_item expected_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_boundary   = 0;
        o_clipped    = 0;
    end

    function automatic logic [10:0] grid_limit(input logic [39:0] data);
        return (data[10:0] > 11'd1024) ? 11'd1024 : data[10:0];
    endfunction

    function automatic t_out_item predict_residual(input t_in_item pt);
        longint             c;
        longint             lin;
        longint             prod_exp;
        longint             k;
        longint             shift;
        longint             res;
        longint unsigned    frac;
        longint unsigned    r;
        longint unsigned    term;
        longint unsigned    mant;
        longint unsigned    react;
        longint unsigned    q;
        longint unsigned    tr;
        logic signed [95:0] span_x;
        logic signed [95:0] span_y;
        bit                 sat;
        t_out_item          o;
        o = '0;
        c = pt.center_value;
        if (pt.col_index == 0 || pt.row_index == 0 ||
            {1'b0, pt.col_index} + 11'd1 >= grid_cols ||
            {1'b0, pt.row_index} + 11'd1 >= grid_rows) begin
            o.residual    = pt.center_value;
            o.on_boundary = 1'b1;
            return o;
        end

        span_x = 2 * c - pt.west_value - pt.east_value;
        span_y = 2 * c - pt.south_value - pt.north_value;
        span_x = span_x * $signed({64'd0, coef_x});
        span_y = span_y * $signed({64'd0, coef_y});
        span_x = (span_x + span_y) >>> 24;
        lin = longint'(span_x);

        prod_exp = c * LOG2_E_FIX;
        k = prod_exp >>> 54;
        frac = $unsigned(prod_exp) & ((64'd1 << 54) - 1);
        frac = frac >> 22;
        r = (frac * LN_2_FIX) >> 32;
        term = 64'd1 << 32;
        mant = term;
        for (int n = 1; n <= EXP_TERMS; n++) begin
            term = ((term * r) >> 32) / n;
            mant = mant + term;
        end
        react = reaction;
        q = mant * (react >> 20) + ((mant * (react & 64'hFFFFF)) >> 20);

        sat = 1'b0;
        tr = 0;
        if (q != 0) begin
            shift = k - 24;
            if (shift >= 0) begin
                if (shift > 43 || q > (CLIP_T >> shift)) begin
                    sat = 1'b1;
                    tr = CLIP_T;
                end else begin
                    tr = q << shift;
                end
            end else if (-shift < 64) begin
                q = q >> (-shift);
                if (q > CLIP_T) begin
                    sat = 1'b1;
                    tr = CLIP_T;
                end else begin
                    tr = q;
                end
            end
        end

        res = lin - $signed(tr);
        if (res > 64'sd2147483647) begin
            res = 64'sd2147483647;
            sat = 1'b1;
        end else if (res < -64'sd2147483648) begin
            res = -64'sd2147483648;
            sat = 1'b1;
        end
        o.residual  = res[31:0];
        o.saturated = sat;
        return o;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            grid_cols = 11'd3;
            grid_rows = 11'd3;
            coef_x    = 32'd16777216;
            coef_y    = 32'd16777216;
            reaction  = 40'd4294967296;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GRID_COLS: grid_cols = grid_limit(i_cfg_data);
                    CFG_GRID_ROWS: grid_rows = grid_limit(i_cfg_data);
                    CFG_COEF_X:    coef_x = i_cfg_data[31:0];
                    CFG_COEF_Y:    coef_y = i_cfg_data[31:0];
                    CFG_REACTION:  reaction = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(predict_residual(i_in_item));
            end
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (i_out_item.on_boundary === 1'b1) o_boundary++;
                if (i_out_item.saturated === 1'b1) o_clipped++;
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORT) begin
                        $display("[%0t] unexpected beat: residual %h sat %b bnd %b", $time,
                                 i_out_item.residual, i_out_item.saturated,
                                 i_out_item.on_boundary);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (want.residual !== i_out_item.residual ||
                        want.saturated !== i_out_item.saturated ||
                        want.on_boundary !== i_out_item.on_boundary) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORT) begin
                            $display("[%0t] mismatch: expected residual %h sat %b bnd %b, got residual %h sat %b bnd %b",
                                     $time, want.residual, want.saturated, want.on_boundary,
                                     i_out_item.residual, i_out_item.saturated,
                                     i_out_item.on_boundary);
                        end
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

@@ bench/bratu_stencil_residual_core_tb.sv @@
`timescale 1ns / 1ps

module bratu_stencil_residual_core_tb;
    import bsr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SEGMENTS     = 3;
    localparam int SEG_POINTS   = 105;

    localparam logic signed [31:0] ONE  = 32'sh0100_0000;
    localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VMIN = 32'sh8000_0000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REACT_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int results;
    int boundary_hits;
    int clip_hits;

    int src_idle;
    int sink_idle;
    int grid_cols_now;
    int grid_rows_now;
    int n_settings;
    int cycle_count;

    bratu_stencil_residual_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bratu_stencil_residual_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_boundary   (boundary_hits),
        .o_clipped    (clip_hits)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        out_ready <= (sink_idle == 0) || ($urandom_range(0, 99) >= sink_idle);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d beats outstanding", cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_in_item make_point(input int col, input int row,
                                            input logic signed [31:0] c,
                                            input logic signed [31:0] w,
                                            input logic signed [31:0] e,
                                            input logic signed [31:0] s,
                                            input logic signed [31:0] n);
        t_in_item pt;
        pt.col_index    = 10'(col);
        pt.row_index    = 10'(row);
        pt.center_value = c;
        pt.west_value   = w;
        pt.east_value   = e;
        pt.south_value  = s;
        pt.north_value  = n;
        return pt;
    endfunction

    function automatic logic signed [31:0] random_value(input int spread_log2);
        return int'($urandom_range(0, (1 << spread_log2) - 1)) - (1 << (spread_log2 - 1));
    endfunction

    function automatic logic signed [31:0] random_center();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return random_value(29);
        if (pick < 7) return random_value(26);
        return $urandom;
    endfunction

    function automatic logic signed [31:0] random_neighbor(input logic signed [31:0] c);
        if ($urandom_range(0, 9) < 6) return c + random_value(24);
        return random_center();
    endfunction

    function automatic logic [IDX_W-1:0] random_index(input int limit);
        int v;
        if ($urandom_range(0, 4) == 0) return 10'($urandom_range(0, 1023));
        v = $urandom_range(0, (limit > 0) ? limit : 1);
        return 10'((v > 1023) ? 1023 : v);
    endfunction

    function automatic t_in_item random_point();
        logic signed [31:0] c;
        c = random_center();
        return make_point(random_index(grid_cols_now), random_index(grid_rows_now), c,
                          random_neighbor(c), random_neighbor(c),
                          random_neighbor(c), random_neighbor(c));
    endfunction

    function automatic logic [REACT_W-1:0] random_coef();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return {8'($urandom), 32'($urandom_range(1 << 22, 1 << 26))};
        if (pick < 8) return {8'($urandom), 32'($urandom)};
        if (pick == 8) return {8'($urandom), 32'd0};
        return {8'($urandom), 32'hFFFF_FFFF};
    endfunction

    function automatic logic [REACT_W-1:0] random_reaction();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return 40'($urandom) << $urandom_range(0, 6);
        if (pick < 7) return {8'($urandom), 32'($urandom)};
        if (pick == 7) return '0;
        return '1;
    endfunction

    task automatic push_point(input t_in_item pt);
        while (src_idle != 0 && $urandom_range(0, 99) < src_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= pt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // drop valid and let every beat in flight come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REACT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [REACT_W-1:0] cols_raw,
                                  input logic [REACT_W-1:0] rows_raw,
                                  input logic [REACT_W-1:0] cx,
                                  input logic [REACT_W-1:0] cy,
                                  input logic [REACT_W-1:0] rc);
        write_reg(CFG_GRID_COLS, cols_raw);
        write_reg(CFG_GRID_ROWS, rows_raw);
        write_reg(CFG_COEF_X, cx);
        write_reg(CFG_COEF_Y, cy);
        write_reg(CFG_REACTION, rc);
        // unmapped index must leave every register alone
        write_reg(CFG_IDX_W'($urandom_range(CFG_REACTION + 1, (1 << CFG_IDX_W) - 1)),
                  {8'($urandom), 32'($urandom)});
        cfg_valid <= 1'b0;
        grid_cols_now = (cols_raw[10:0] > MAX_GRID) ? int'(MAX_GRID) : int'(cols_raw[10:0]);
        grid_rows_now = (rows_raw[10:0] > MAX_GRID) ? int'(MAX_GRID) : int'(rows_raw[10:0]);
        n_settings++;
    endtask

    task automatic random_settings();
        logic [REACT_W-1:0] cols_raw;
        logic [REACT_W-1:0] rows_raw;
        int                 pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            cols_raw = $urandom_range(3, 24);
            rows_raw = $urandom_range(3, 24);
        end else if (pick < 7) begin
            cols_raw = $urandom_range(3, 1024);
            rows_raw = $urandom_range(3, 1024);
        end else if (pick == 7) begin
            cols_raw = 3;
            rows_raw = 3;
        end else if (pick == 8) begin
            cols_raw = $urandom_range(1025, 2047);
            rows_raw = 1024;
        end else begin
            cols_raw = $urandom_range(0, 2);
            rows_raw = $urandom_range(0, 1024);
        end
        cols_raw[39:11] = 29'($urandom);
        rows_raw[39:11] = 29'($urandom);
        apply_settings(cols_raw, rows_raw, random_coef(), random_coef(), random_reaction());
    endtask

    initial begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        src_idle    = 12;
        sink_idle   = 70;
        n_settings  = 0;
        cycle_count = 0;
        grid_cols_now = 3;
        grid_rows_now = 3;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: 3 x 3 grid, unit coefficients, reaction 1/16
        push_point(make_point(1, 1, 0, 0, 0, 0, 0));
        push_point(make_point(0, 1, random_center(), $urandom, $urandom, $urandom, $urandom));
        push_point(make_point(2, 1, random_center(), $urandom, $urandom, $urandom, $urandom));
        push_point(make_point(1, 2, random_center(), $urandom, $urandom, $urandom, $urandom));
        push_point(make_point(1, 0, random_center(), $urandom, $urandom, $urandom, $urandom));
        push_point(make_point(1023, 1023, VMIN, VMAX, VMAX, VMAX, VMAX));

        wait_idle();
        apply_settings('1, 40'd1024, 40'hFFFF_FFFF, 40'd0, 40'd0);
        push_point(make_point(1022, 1022, 0, VMIN, VMIN, VMAX, VMAX));
        push_point(make_point(1023, 5, VMAX, VMIN, VMIN, VMIN, VMIN));
        push_point(make_point(5, 1023, VMIN, VMAX, VMAX, VMAX, VMAX));
        push_point(make_point(1, 1, VMAX, VMAX, VMAX, VMIN, VMIN));
        push_point(make_point(500, 500, VMIN, VMAX, VMAX, 0, 0));

        wait_idle();
        apply_settings(40'd1024, 40'd3000, 40'(ONE), 40'(ONE), '1);
        push_point(make_point(7, 9, VMAX, VMAX, VMAX, VMAX, VMAX));
        push_point(make_point(7, 9, VMIN, VMIN, VMIN, VMIN, VMIN));
        push_point(make_point(7, 9, 0, 0, 0, 0, 0));
        push_point(make_point(7, 9, ONE * 10, ONE, ONE, ONE, ONE));
        push_point(make_point(7, 9, ONE * 11, ONE, ONE, ONE, ONE));
        push_point(make_point(7, 9, -ONE, $urandom, $urandom, $urandom, $urandom));

        wait_idle();
        apply_settings(40'd0, 40'd2053, 40'(ONE), 40'(ONE), 40'd4294967296);
        push_point(make_point(1, 1, random_center(), 0, 0, 0, 0));
        push_point(make_point(3, 3, random_center(), 0, 0, 0, 0));

        wait_idle();
        apply_settings(40'd2, 40'd4, random_coef(), random_coef(), random_reaction());
        push_point(make_point(1, 1, random_center(), 0, 0, 0, 0));
        push_point(make_point(1, 2, random_center(), 0, 0, 0, 0));

        for (int phase = 0; phase < 3; phase++) begin
            src_idle  = (phase == 0) ? 12 : (phase == 1) ? 70 : 0;
            sink_idle = (phase == 0) ? 70 : (phase == 1) ? 12 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                wait_idle();
                random_settings();
                repeat (SEG_POINTS) push_point(random_point());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d grid points (%0d on the boundary, %0d clipped) over %0d register settings,",
                 results, boundary_hits, clip_hits, n_settings);
        $display("with sender-side stalls, receiver-side stalls and back-to-back streaming.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatched beats", fail_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
